// ----- hdl/max_sum_subrectangle_top_defines.svh -----
// Assertion macros for the max-sum subrectangle RTL.
`ifndef MAX_SUM_SUBRECTANGLE_TOP_DEFINES_SVH
`define MAX_SUM_SUBRECTANGLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off during reset
`define MSR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msr: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset
`define MSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msr: next-cycle check failed");
`else
`define MSR_ASSERT_IMPL(label, ante, cons)
`define MSR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/msr_pkg.sv -----
// Shared types, constants and the microcode ROM of the max-sum subrectangle block.
package msr_pkg;

  // fixed field widths
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_OUT_W  = 27;
  localparam int CORNER_W   = 6;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_W-1:0]     SIZE_RESET       = 6'd32;

  // datapath action of one micro step
  typedef enum logic [3:0] {
    OP_LOAD       = 4'd0,
    OP_INIT_LEFT  = 4'd1,
    OP_INIT_RIGHT = 4'd2,
    OP_INIT_ROW   = 4'd3,
    OP_COL_ADD    = 4'd4,
    OP_KADANE     = 4'd5,
    OP_PAIR       = 4'd6,
    OP_NEXT_LEFT  = 4'd7,
    OP_EMIT       = 4'd8
  } op_t;

  // jump condition of one micro step
  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_LAUNCH  = 3'd2,
    C_MORE_ROWS  = 3'd3,
    C_MORE_RIGHT = 3'd4,
    C_MORE_LEFT  = 3'd5
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // status from the datapath that the sequencer branches on
  typedef struct packed {
    logic launch;
    logic more_rows;
    logic more_right;
    logic more_left;
  } flags_t;

  // program addresses
  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_INIT_L   = 4'd1;
  localparam upc_t UPC_INIT_R   = 4'd2;
  localparam upc_t UPC_INIT_I   = 4'd3;
  localparam upc_t UPC_COL_ADD  = 4'd4;
  localparam upc_t UPC_KADANE   = 4'd5;
  localparam upc_t UPC_PAIR     = 4'd6;
  localparam upc_t UPC_NEXT_L   = 4'd7;
  localparam upc_t UPC_EMIT     = 4'd8;

  // microcode ROM: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    unique case (pc)
      UPC_IDLE:    w = '{op: OP_LOAD,       cond: C_NO_LAUNCH,  target: UPC_IDLE};
      UPC_INIT_L:  w = '{op: OP_INIT_LEFT,  cond: C_NEVER,      target: UPC_IDLE};
      UPC_INIT_R:  w = '{op: OP_INIT_RIGHT, cond: C_NEVER,      target: UPC_IDLE};
      UPC_INIT_I:  w = '{op: OP_INIT_ROW,   cond: C_NEVER,      target: UPC_IDLE};
      UPC_COL_ADD: w = '{op: OP_COL_ADD,    cond: C_NEVER,      target: UPC_IDLE};
      UPC_KADANE:  w = '{op: OP_KADANE,     cond: C_MORE_ROWS,  target: UPC_COL_ADD};
      UPC_PAIR:    w = '{op: OP_PAIR,       cond: C_MORE_RIGHT, target: UPC_INIT_I};
      UPC_NEXT_L:  w = '{op: OP_NEXT_LEFT,  cond: C_MORE_LEFT,  target: UPC_INIT_R};
      UPC_EMIT:    w = '{op: OP_EMIT,       cond: C_ALWAYS,     target: UPC_IDLE};
      default:     w = '{op: OP_LOAD,       cond: C_ALWAYS,     target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/msr_seq.sv -----
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module msr_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  msr_pkg::flags_t flags,
  output msr_pkg::ctrl_t  ctrl,
  output logic            idle
);
  import msr_pkg::*;

  upc_t pc_r;
  upc_t pc_nxt;
  logic take;

  assign ctrl = ucode(pc_r);
  assign idle = (pc_r == UPC_IDLE);

  // branch condition
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_LAUNCH:  take = !flags.launch;
      C_MORE_ROWS:  take = flags.more_rows;
      C_MORE_RIGHT: take = flags.more_right;
      C_MORE_LEFT:  take = flags.more_left;
      default:      take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? ctrl.target : pc_r + upc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hdl/max_sum_subrectangle_top.sv -----
// Top level of the max-sum subrectangle search: loader, matrix memory and datapath.
//
// Entries arrive one beat per cycle in row-major order while busy is low; a beat
// is taken on any edge with start high and busy low. After the last entry of a
// rows x cols matrix the block raises busy and searches every column pair with a
// two-step row loop (matrix and column-sum memory read plus add, then the Kadane
// compare). The search ends with one cycle of out_valid that carries the best sum
// and its 1-based corners; the receiver cannot stall it, so out_valid must be
// sampled when high. Configuration writes are always ready, restart loading, and
// belong in idle time.
`include "max_sum_subrectangle_top_defines.svh"

module max_sum_subrectangle_top #(
  parameter int MAX_ROWS      = 32,
  parameter int MAX_COLUMNS   = 32,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input item
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_element_value,
  // result
  output logic                                  out_valid,
  output logic signed [msr_pkg::SUM_OUT_W-1:0]  out_best_sum,
  output logic [msr_pkg::CORNER_W-1:0]          out_top_row,
  output logic [msr_pkg::CORNER_W-1:0]          out_left_column,
  output logic [msr_pkg::CORNER_W-1:0]          out_bottom_row,
  output logic [msr_pkg::CORNER_W-1:0]          out_right_column,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [msr_pkg::CFG_W-1:0]             cfg_data
);
  import msr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);
  localparam int CSW   = ELEMENT_WIDTH + $clog2(MAX_COLUMNS) + 1;
  localparam int SW    = ELEMENT_WIDTH + $clog2(DEPTH) + 1;

  // sequencer
  ctrl_t  ctrl;
  flags_t flags;
  logic   idle;

  msr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  // configuration registers and effective sizes
  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] column_count_r;
  logic [RCW-1:0]   rows_eff;
  logic [CCW-1:0]   cols_eff;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= SIZE_RESET;
      column_count_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count_r <= cfg_data;
      end else if (cfg_index == REG_COLUMN_COUNT) begin
        column_count_r <= cfg_data;
      end
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    priority if (row_count_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_count_r);
    end
    priority if (column_count_r == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(column_count_r) > MAX_COLUMNS) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = CCW'(column_count_r);
    end
  end

  // load position
  logic [RIW-1:0] ld_row_r;
  logic [CIW-1:0] ld_col_r;
  logic [AW-1:0]  ld_base_r;
  logic           in_beat;
  logic           ld_last_col;
  logic           ld_last;

  assign busy        = !idle;
  assign in_beat     = start && idle;
  assign ld_last_col = (CCW'(ld_col_r) == cols_eff - CCW'(1));
  assign ld_last     = ld_last_col && (RCW'(ld_row_r) == rows_eff - RCW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      ld_row_r  <= '0;
      ld_col_r  <= '0;
      ld_base_r <= '0;
    end else if (in_beat) begin
      if (ld_last) begin
        ld_row_r  <= '0;
        ld_col_r  <= '0;
        ld_base_r <= '0;
      end else if (ld_last_col) begin
        ld_row_r  <= ld_row_r + RIW'(1);
        ld_col_r  <= '0;
        ld_base_r <= ld_base_r + AW'(MAX_COLUMNS);
      end else begin
        ld_col_r <= ld_col_r + CIW'(1);
      end
    end
  end

  // search indices and running values
  logic [CIW-1:0]          left_r, right_r;
  logic [RIW-1:0]          i_r, cand_r, start_r, end_r;
  logic [AW-1:0]           rbase_r;
  logic signed [CSW-1:0]   col_r;
  logic signed [SW-1:0]    run_r, here_r, best_r;
  logic [RIW-1:0]          best_top_r, best_bot_r;
  logic [CIW-1:0]          best_left_r, best_right_r;
  logic signed [SW-1:0]    run_t;

  assign flags.launch     = in_beat && ld_last;
  assign flags.more_rows  = (RCW'(i_r) != rows_eff - RCW'(1));
  assign flags.more_right = (CCW'(right_r) != cols_eff - CCW'(1));
  assign flags.more_left  = (CCW'(left_r) != cols_eff - CCW'(1));

  // memory read requests: first row on INIT_ROW, next row during KADANE
  logic                  rd_en;
  logic [AW-1:0]         mat_rd_addr;
  logic [RIW-1:0]        ps_rd_addr;
  logic signed [ELEMENT_WIDTH-1:0] mat_q;
  logic signed [CSW-1:0] ps_q;
  logic                  ps_wr;

  always_comb begin
    rd_en       = 1'b0;
    mat_rd_addr = AW'(right_r);
    ps_rd_addr  = '0;
    if (ctrl.op == OP_INIT_ROW) begin
      rd_en = 1'b1;
    end else if (ctrl.op == OP_KADANE && flags.more_rows) begin
      rd_en       = 1'b1;
      mat_rd_addr = rbase_r + AW'(right_r);
      ps_rd_addr  = i_r + RIW'(1);
    end
  end

  assign ps_wr = (ctrl.op == OP_COL_ADD);

  // matrix store
  logic signed [ELEMENT_WIDTH-1:0] mat_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (in_beat) begin
      mat_mem[ld_base_r + AW'(ld_col_r)] <= in_element_value;
    end
    if (rd_en) begin
      mat_q <= mat_mem[mat_rd_addr];
    end
  end

  // per-row column sums for the current left column
  logic signed [CSW-1:0] ps_mem [MAX_ROWS];
  logic signed [CSW-1:0] col_sum;

  assign col_sum = ((right_r == left_r) ? CSW'(0) : ps_q) + CSW'(mat_q);

  always_ff @(posedge clk) begin
    if (ps_wr) begin
      ps_mem[i_r] <= col_sum;
    end
    if (rd_en) begin
      ps_q <= ps_mem[ps_rd_addr];
    end
  end

  assign run_t = run_r + SW'(col_r);

  // datapath actions
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
      end
      OP_INIT_LEFT: begin
        left_r <= '0;
      end
      OP_INIT_RIGHT: begin
        right_r <= left_r;
      end
      OP_INIT_ROW: begin
        i_r     <= '0;
        run_r   <= '0;
        cand_r  <= '0;
        rbase_r <= AW'(MAX_COLUMNS);
      end
      OP_COL_ADD: begin
        col_r <= col_sum;
      end
      OP_KADANE: begin
        // first row always seeds the best-here value
        if (i_r == '0 || run_t > here_r) begin
          here_r  <= run_t;
          start_r <= cand_r;
          end_r   <= i_r;
        end
        if (run_t < 0) begin
          run_r  <= '0;
          cand_r <= i_r + RIW'(1);
        end else begin
          run_r <= run_t;
        end
        i_r     <= i_r + RIW'(1);
        rbase_r <= rbase_r + AW'(MAX_COLUMNS);
      end
      OP_PAIR: begin
        // strict compare keeps the first rectangle on a tie
        if ((left_r == '0 && right_r == '0) || here_r > best_r) begin
          best_r       <= here_r;
          best_top_r   <= start_r;
          best_bot_r   <= end_r;
          best_left_r  <= left_r;
          best_right_r <= right_r;
        end
        right_r <= right_r + CIW'(1);
      end
      OP_NEXT_LEFT: begin
        left_r <= left_r + CIW'(1);
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // result beat
  assign out_valid        = (ctrl.op == OP_EMIT);
  assign out_best_sum     = SUM_OUT_W'(best_r);
  assign out_top_row      = CORNER_W'({1'b0, best_top_r} + (RIW+1)'(1));
  assign out_bottom_row   = CORNER_W'({1'b0, best_bot_r} + (RIW+1)'(1));
  assign out_left_column  = CORNER_W'({1'b0, best_left_r} + (CIW+1)'(1));
  assign out_right_column = CORNER_W'({1'b0, best_right_r} + (CIW+1)'(1));

  // checks
  `MSR_ASSERT_NEXT(a_launch_busy, flags.launch, busy)
  `MSR_ASSERT_NEXT(a_plain_beat_idle, in_beat && !ld_last, !busy)
  `MSR_ASSERT_NEXT(a_result_then_idle, out_valid, !busy && !out_valid)
  `MSR_ASSERT_IMPL(a_row_in_range, ctrl.op == OP_KADANE, RCW'(i_r) < rows_eff)
  `MSR_ASSERT_IMPL(a_corner_order, out_valid, best_left_r <= best_right_r && best_top_r <= best_bot_r)

endmodule
